// ===== sv/vfd_pkg.sv =====
// Shared widths, codes and handshake structs of the video frame decimator.
package vfd_pkg;

	localparam int INTERVAL_W = 20;
	localparam int MAX_TIME_W = 36;
	localparam int DUR_W      = 24;
	localparam int VERDICT_W  = 2;
	localparam int STAMP_W    = 28;
	localparam int REC_W      = 37;
	localparam int NEXT_W     = 38;
	localparam int MID2_W     = 39;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 36;

	// divider: dividend spans the recorded time, divisor the interval
	localparam int NUM_W = REC_W;
	localparam int DEN_W = INTERVAL_W;
	localparam int CNT_W = $clog2(NUM_W + 1);

	// millisecond rounding: divide by 8, then by 125 through a reciprocal
	localparam int MS_SHIFT    = 3;
	localparam int MS_M_W      = NUM_W - MS_SHIFT;
	localparam int RECIP_W     = 35;
	localparam int MS_QUOT_LSB = 41;
	localparam int PROD_W      = MS_M_W + RECIP_W;
	localparam int MUL_A_W     = MS_M_W / 2;
	localparam int MUL_B_W     = RECIP_W - MUL_A_W;
	localparam int PP_W        = MUL_A_W + MUL_B_W;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(33333);
	localparam logic [MAX_TIME_W-1:0] MAX_TIME_RST = MAX_TIME_W'(600000000);

	localparam logic [NUM_W-1:0] MS_HALF = NUM_W'(500);
	// ceil(2^41 / 125), exact for every quotient of a dividend below 2^34
	localparam logic [RECIP_W-1:0] MS_RECIP = RECIP_W'(64'd17592186045);

	localparam logic [VERDICT_W-1:0] VERDICT_CAPTURE = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_SKIP    = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_LIMIT   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME = 1'b1;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DEN_W-1:0] remainder;
	} div_rsp_t;

endpackage

// ===== sv/vfd_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module vfd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  vfd_pkg::div_req_t  req,
	output vfd_pkg::div_rsp_t  rsp
);
	import vfd_pkg::*;

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   rem_sh;
	logic             ge;
	logic [DEN_W:0]   rem_nxt;

	always_comb begin
		rem_sh  = {rem_q, num_q[NUM_W-1]};
		ge      = (rem_sh >= {1'b0, den_q});
		rem_nxt = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift quotient bits in from the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (run_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= rem_nxt[DEN_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== sv/video_frame_decimator.sv =====
// Top level of the video frame decimator: sequencer, state and output register.
// One transaction at a time. A leave-out mark passes through decide only, and a
// frame that is skipped or hits the length limit without arithmetic goes through
// decide and emit. A frame whose midpoint reaches the capture time goes through
// decide and prepare, the 37-step bit-serial divider for the remainder that
// advances the capture time by whole intervals, a 17 x 18 partial product
// multiply that rounds the start time to milliseconds, one stamp check
// and one emit. The finished result sits in an output register, so the next
// transaction is taken while it waits; a result that finds that register still
// stalled holds the sequencer until it drains. Configuration writes apply at
// once and are meant for an idle block.
module video_frame_decimator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [vfd_pkg::DUR_W-1:0]         frame_duration_us,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [vfd_pkg::VERDICT_W-1:0]     verdict,
	output logic [vfd_pkg::STAMP_W-1:0]       timestamp_ms,
	input  logic                              cfg_we,
	input  logic [vfd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vfd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import vfd_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_DECIDE  = 3'd1;
	localparam logic [2:0] ST_PREP    = 3'd2;
	localparam logic [2:0] ST_DIV_REM = 3'd3;
	localparam logic [2:0] ST_MUL     = 3'd4;
	localparam logic [2:0] ST_STAMP   = 3'd5;
	localparam logic [2:0] ST_EMIT    = 3'd6;

	localparam logic [MUL_B_W-1:0] RECIP_LO = MS_RECIP[MUL_B_W-1:0];
	localparam logic [MUL_B_W-1:0] RECIP_HI = MUL_B_W'(MS_RECIP[RECIP_W-1:MUL_B_W]);

	logic [2:0]            state_q;

	logic [INTERVAL_W-1:0] interval_q;
	logic [MAX_TIME_W-1:0] max_time_q;
	logic [REC_W-1:0]      recorded_q;
	logic [NEXT_W-1:0]     next_capture_q;
	logic [STAMP_W-1:0]    last_stamp_q;
	logic                  have_stamp_q;
	logic                  pending_q;

	logic                  action_q;
	logic [DUR_W-1:0]      dur_q;
	logic [REC_W-1:0]      start_q;
	logic [NEXT_W-1:0]     mid_floor_q;
	logic [VERDICT_W-1:0]  res_verdict_q;
	logic [STAMP_W-1:0]    res_stamp_q;
	logic [NUM_W-1:0]      ms_num_q;
	logic [1:0]            mul_cnt_q;
	logic [PROD_W-1:0]     acc_q;

	logic                  out_valid_q;
	logic [VERDICT_W-1:0]  verdict_q;
	logic [STAMP_W-1:0]    timestamp_q;

	logic [INTERVAL_W-1:0] ival_eff;
	logic [MID2_W-1:0]     mid2;
	logic                  below_next;
	logic                  at_limit;
	logic                  emit_go;
	logic [STAMP_W-1:0]    stamp;
	logic                  stamp_new;
	logic [MUL_A_W-1:0]    mul_a;
	logic [MUL_B_W-1:0]    mul_b;
	logic [PP_W-1:0]       mul_pp;
	logic [PROD_W-1:0]     mul_term;

	div_req_t              div_req;
	div_rsp_t              div_rsp;

	vfd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		ival_eff   = (interval_q == '0) ? INTERVAL_W'(1) : interval_q;
		mid2       = MID2_W'({recorded_q, 1'b0}) + MID2_W'(dur_q);
		below_next = (mid2 < {next_capture_q, 1'b0});
		at_limit   = (recorded_q >= REC_W'(max_time_q));
		emit_go    = !out_valid_q || !out_stall;
		stamp      = acc_q[MS_QUOT_LSB +: STAMP_W];
		stamp_new  = !have_stamp_q || (stamp > last_stamp_q);

		div_req.start    = (state_q == ST_PREP);
		div_req.dividend = REC_W'(mid_floor_q - next_capture_q);
		div_req.divisor  = ival_eff;
	end

	// one 17 x 18 partial product of (start + 500) / 8 times the reciprocal per cycle
	always_comb begin
		mul_a = ms_num_q[MS_SHIFT +: MUL_A_W];
		mul_b = RECIP_LO;
		if (mul_cnt_q[1]) begin
			mul_a = ms_num_q[MS_SHIFT + MUL_A_W +: MUL_A_W];
		end
		if (mul_cnt_q[0]) begin
			mul_b = RECIP_HI;
		end
		mul_pp = PP_W'(mul_a) * PP_W'(mul_b);
		case (mul_cnt_q)
			2'd0: mul_term = PROD_W'(mul_pp);
			2'd1: mul_term = PROD_W'(mul_pp) << MUL_B_W;
			2'd2: mul_term = PROD_W'(mul_pp) << MUL_A_W;
			default: mul_term = PROD_W'(mul_pp) << PP_W;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RST;
			max_time_q <= MAX_TIME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTERVAL: interval_q <= cfg_data[INTERVAL_W-1:0];
				REG_MAX_TIME: max_time_q <= cfg_data[MAX_TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			recorded_q     <= '0;
			next_capture_q <= '0;
			last_stamp_q   <= '0;
			have_stamp_q   <= 1'b0;
			pending_q      <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (action_q) begin
						pending_q <= 1'b1;
						state_q   <= ST_IDLE;
					end else if (dur_q == '0) begin
						state_q <= ST_EMIT;
					end else if (pending_q) begin
						pending_q <= 1'b0;
						state_q   <= ST_EMIT;
					end else if (at_limit) begin
						state_q <= ST_EMIT;
					end else begin
						recorded_q <= recorded_q + REC_W'(dur_q);
						state_q    <= below_next ? ST_EMIT : ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_DIV_REM;
				end
				ST_DIV_REM: begin
					// land one interval past the midpoint, minus the leftover
					if (div_rsp.done) begin
						next_capture_q <= mid_floor_q - NEXT_W'(div_rsp.remainder)
							+ NEXT_W'(ival_eff);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_cnt_q == 2'd3) begin
						state_q <= ST_STAMP;
					end
				end
				ST_STAMP: begin
					if (stamp_new) begin
						last_stamp_q <= stamp;
						have_stamp_q <= 1'b1;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			action_q <= action;
			dur_q    <= frame_duration_us;
		end
		if (state_q == ST_DECIDE) begin
			start_q       <= recorded_q;
			mid_floor_q   <= mid2[MID2_W-1:1];
			res_stamp_q   <= '0;
			res_verdict_q <= (dur_q != '0 && !pending_q && at_limit) ?
				VERDICT_LIMIT : VERDICT_SKIP;
		end
		if (state_q == ST_PREP) begin
			ms_num_q  <= start_q + MS_HALF;
			mul_cnt_q <= '0;
			acc_q     <= '0;
		end
		if (state_q == ST_MUL) begin
			acc_q     <= acc_q + mul_term;
			mul_cnt_q <= mul_cnt_q + 2'd1;
		end
		if (state_q == ST_STAMP && stamp_new) begin
			res_verdict_q <= VERDICT_CAPTURE;
			res_stamp_q   <= stamp;
		end
		if (state_q == ST_EMIT && emit_go) begin
			verdict_q   <= res_verdict_q;
			timestamp_q <= res_stamp_q;
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign verdict      = verdict_q;
	assign timestamp_ms = timestamp_q;

	// divider results only show up while the sequencer waits on them
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV_REM))
		else $error("divider finished outside a divide state");

	// the advanced capture time must lie past the frame midpoint
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_REM && div_rsp.done) |=> (next_capture_q > mid_floor_q))
		else $error("capture time not advanced past midpoint");

	// a captured timestamp is the one recorded as last given out
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && emit_go && res_verdict_q == VERDICT_CAPTURE)
		|=> (have_stamp_q && timestamp_ms == last_stamp_q))
		else $error("captured timestamp differs from last stamp");

endmodule

// ===== verif/video_frame_decimator_tb.sv =====
// Self-checking testbench of the video frame decimator: directed and randomized frames against a local model.
`timescale 1ns / 100ps

module video_frame_decimator_tb;
	import vfd_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE_CYCLES = 100;
	localparam int LONG_HOLD = 400;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 100;

	typedef struct packed {
		logic             act;
		logic [DUR_W-1:0] dur;
	} frame_item_t;

	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic [STAMP_W-1:0]   stamp;
	} verdict_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  action = 1'b0;
	logic [DUR_W-1:0]      frame_duration_us = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [VERDICT_W-1:0]  verdict;
	logic [STAMP_W-1:0]    timestamp_ms;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// local copy of the block's registers and state
	logic [INTERVAL_W-1:0] interval_cfg = INTERVAL_RST;
	logic [MAX_TIME_W-1:0] max_time_cfg = MAX_TIME_RST;
	logic [REC_W-1:0]      rec_us = '0;
	logic [NEXT_W-1:0]     next_cap_us = '0;
	longint                last_stamp = -1;
	logic                  skip_mark = 1'b0;

	frame_item_t frame_q[$];
	verdict_t    verdict_q[$];
	frame_item_t cur;
	verdict_t    exp_v;
	logic        offer_taken = 1'b0;
	int          burst_left = 0;
	int          gap_left = 0;
	logic        hold_req = 1'b0;
	int          hold_left = 0;
	int          mode_left = 0;
	int          stall_pct = 0;
	int          fail_cnt = 0;
	int          cycle_cnt = 0;

	video_frame_decimator i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.action            (action),
		.frame_duration_us (frame_duration_us),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.verdict           (verdict),
		.timestamp_ms      (timestamp_ms),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic decide_frame(input logic act, input logic [DUR_W-1:0] dur);
		longint unsigned start_us, mid2, next_cur, ival, steps, stamp;
		verdict_t v;
		v.verdict = VERDICT_SKIP;
		v.stamp = '0;
		if (act) begin
			skip_mark = 1'b1;
			return;
		end
		if (dur == '0) begin
			verdict_q.push_back(v);
			return;
		end
		if (skip_mark) begin
			skip_mark = 1'b0;
			verdict_q.push_back(v);
			return;
		end
		start_us = rec_us;
		if (start_us >= max_time_cfg) begin
			v.verdict = VERDICT_LIMIT;
			verdict_q.push_back(v);
			return;
		end
		rec_us = REC_W'(start_us + dur);
		next_cur = next_cap_us;
		// compare doubled midpoint in half-microsecond steps
		mid2 = 2 * start_us + dur;
		if (mid2 >= 2 * next_cur) begin
			ival = (interval_cfg == '0) ? 1 : interval_cfg;
			steps = ((mid2 >> 1) - next_cur) / ival + 1;
			next_cap_us = NEXT_W'(next_cur + steps * ival);
			stamp = (start_us + 500) / 1000;
			if (longint'(stamp) > last_stamp) begin
				last_stamp = stamp;
				v.verdict = VERDICT_CAPTURE;
				v.stamp = STAMP_W'(stamp);
			end
		end
		verdict_q.push_back(v);
	endtask

	task automatic push_frame(input logic act, input logic [DUR_W-1:0] dur);
		frame_item_t f;
		f.act = act;
		f.dur = dur;
		frame_q.push_back(f);
	endtask

	function automatic frame_item_t random_frame();
		frame_item_t f;
		int unsigned span;
		span = (interval_cfg < 1000) ? 2000 : 2 * interval_cfg;
		f.act = 1'b0;
		f.dur = DUR_W'($urandom);
		case ($urandom_range(0, 19))
			0, 1: f.act = 1'b1;
			2, 3: f.dur = '0;
			4, 5, 6: f.dur = DUR_W'($urandom_range(1, 1500));
			7: f.dur = $urandom_range(0, 1) ? {DUR_W{1'b1}} : DUR_W'(1);
			8, 9, 10: ;
			default: f.dur = DUR_W'($urandom_range(1, span));
		endcase
		return f;
	endfunction

	// wait until every transaction is in and out, then let the block go quiet
	task automatic wait_idle();
		while (frame_q.size() != 0 || in_valid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_INTERVAL)
			interval_cfg = data[INTERVAL_W-1:0];
		else
			max_time_cfg = data[MAX_TIME_W-1:0];
	endtask

	// sender: accept at the rising edge, offer the next transaction at the falling edge
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			decide_frame(action, frame_duration_us);
			offer_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || offer_taken)) begin
			offer_taken = 1'b0;
			if (gap_left > 0 || frame_q.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				in_valid <= 1'b0;
			end else begin
				cur = frame_q.pop_front();
				in_valid <= 1'b1;
				action <= cur.act;
				frame_duration_us <= cur.dur;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					case ($urandom_range(0, 2))
						0: gap_left = 0;
						1: gap_left = $urandom_range(1, 8);
						default: gap_left = $urandom_range(1, 90);
					endcase
				end
			end
		end
	end

	// receiver: stall pattern of its own, plus a long hold on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				mode_left = $urandom_range(8, 150);
				case ($urandom_range(0, 4))
					0, 1: stall_pct = 0;
					2: stall_pct = 30;
					3: stall_pct = 70;
					default: stall_pct = 95;
				endcase
			end
			mode_left--;
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected result: verdict %0d timestamp_ms %0d",
					$time, verdict, timestamp_ms);
				fail_cnt++;
			end else begin
				exp_v = verdict_q.pop_front();
				if (verdict !== exp_v.verdict) begin
					$display("%0t: verdict expected %0d, got %0d",
						$time, exp_v.verdict, verdict);
					fail_cnt++;
				end
				if (timestamp_ms !== exp_v.stamp) begin
					$display("%0t: timestamp_ms expected %0d, got %0d",
						$time, exp_v.stamp, timestamp_ms);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: first capture, zero durations, leave-out marks, equal stamps
		push_frame(1'b0, DUR_W'(1));
		push_frame(1'b0, '0);
		push_frame(1'b1, {DUR_W{1'b1}});
		push_frame(1'b1, '0);
		push_frame(1'b0, '0);
		push_frame(1'b0, {DUR_W{1'b1}});
		push_frame(1'b0, {DUR_W{1'b1}});
		push_frame(1'b0, DUR_W'(1000));
		push_frame(1'b0, DUR_W'(1));
		push_frame(1'b0, DUR_W'(100));
		push_frame(1'b0, DUR_W'(33333));
		push_frame(1'b0, DUR_W'(500));
		wait_idle();

		// zero interval behaves as one; upper data bits are dropped
		write_reg(REG_INTERVAL, 36'hF_FFF0_0000);
		push_frame(1'b0, DUR_W'(1));
		push_frame(1'b0, DUR_W'(1));
		push_frame(1'b0, DUR_W'(1));
		push_frame(1'b0, DUR_W'(999));
		wait_idle();

		// zero length limit: a pending mark still wins over the limit
		write_reg(REG_MAX_TIME, '0);
		push_frame(1'b0, DUR_W'(50));
		push_frame(1'b1, '0);
		push_frame(1'b0, DUR_W'(50));
		push_frame(1'b0, '0);
		wait_idle();

		write_reg(REG_INTERVAL, 36'h0_000F_FFFF);
		write_reg(REG_MAX_TIME, {CFG_DATA_W{1'b1}});
		push_frame(1'b0, {DUR_W{1'b1}});
		push_frame(1'b0, DUR_W'(1));
		push_frame(1'b0, DUR_W'(20'hFFFFF));
		push_frame(1'b0, DUR_W'(600));

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			case (p)
				0: begin
					write_reg(REG_INTERVAL, CFG_DATA_W'(33333));
					hold_req = 1'b1;
				end
				1: begin
					write_reg(REG_INTERVAL, CFG_DATA_W'(16667));
					write_reg(REG_MAX_TIME,
						CFG_DATA_W'(rec_us) + CFG_DATA_W'($urandom_range(50000000, 150000000)));
				end
				2: begin
					write_reg(REG_INTERVAL, 36'hA_BCD0_0001);
					write_reg(REG_MAX_TIME, {CFG_DATA_W{1'b1}});
				end
				3: begin
					write_reg(REG_INTERVAL, CFG_DATA_W'(1000000));
					write_reg(REG_MAX_TIME,
						CFG_DATA_W'(rec_us) + CFG_DATA_W'($urandom_range(30000000, 100000000)));
					hold_req = 1'b1;
				end
				4: begin
					write_reg(REG_INTERVAL, CFG_DATA_W'($urandom_range(16667, 1000000)));
					write_reg(REG_MAX_TIME, {CFG_DATA_W{1'b1}});
				end
				default: begin
					write_reg(REG_INTERVAL, CFG_DATA_W'(16667));
					write_reg(REG_MAX_TIME,
						CFG_DATA_W'(rec_us) + CFG_DATA_W'($urandom_range(20000000, 80000000)));
				end
			endcase
			repeat (PHASE_ITEMS) frame_q.push_back(random_frame());
		end

		wait_idle();
		if (fail_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
